// ----- hdl/rts_pkg.sv -----
// Shared types and constants of the radio timing sequencer.
// No dependencies; the core, front end, back end and testbench import this package.
package rts_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned FRAME_W = 22;
  localparam int unsigned QB_W    = 13;
  localparam int unsigned MASK_W  = 32;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] INSN_AT      = 3'd1;
  localparam logic [2:0] INSN_OFFSET  = 3'd2;
  localparam logic [2:0] INSN_SYNCHRO = 3'd3;
  localparam logic [2:0] INSN_MOVE    = 3'd4;
  localparam logic [2:0] INSN_WAIT    = 3'd5;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_START,
    CMD_TICK
  } rts_cmd_e;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_SYNCHRO = 2'd1,
    KIND_OFFSET  = 2'd2,
    KIND_MOVE    = 2'd3
  } rts_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_COPY_TAIL,
    ST_RUN,
    ST_DIV,
    ST_DONE
  } rts_state_e;

  typedef struct packed {
    rts_cmd_e             kind;
    logic [INDEX_W-1:0]   index;
    logic [WORD_W-1:0]    word;
    logic [FRAME_W-1:0]   frame;
  } rts_cmd_t;

  typedef struct packed {
    rts_kind_e            kind;
    logic [QB_W-1:0]      reg_value;
    logic [4:0]           move_addr;
    logic [7:0]           move_data;
    logic [FRAME_W-1:0]   move_frame;
  } rts_result_t;

endpackage

// ----- hdl/rts_if.sv -----
// Handshake channels of the radio timing sequencer: input items, results and
// the configuration write channel. Depends on nothing.
interface rts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  word_index;
  logic [15:0] word;
  logic [21:0] frame_number;

  modport source(output valid, operation, word_index, word, frame_number, input ready);
  modport sink(input valid, operation, word_index, word, frame_number, output ready);
endinterface

interface rts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [12:0] reg_value;
  logic [4:0]  move_addr;
  logic [7:0]  move_data;
  logic [21:0] move_frame;
  logic        running;
  logic        last;

  modport source(output valid, kind, reg_value, move_addr, move_data, move_frame, running,
                 last, input ready);
  modport sink(input valid, kind, reg_value, move_addr, move_data, move_frame, running, last,
               output ready);
endinterface

interface rts_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] owned_port_mask;

  modport source(output valid, owned_port_mask, input ready);
  modport sink(input valid, owned_port_mask, output ready);
endinterface

// ----- hdl/radio_timing_sequencer_core.sv -----
// A load, a tick without resume or an ignored item goes from ST_IDLE to ST_DONE, which
// registers its result. A start copies the staging store in ST_COPY and ST_COPY_TAIL, then
// walks one program word per cycle while the result register is free; a frame-wrapping wait
// divides in ST_DIV. The back end takes one item at a time; a two-entry queue and a result
// register decouple the input and output sides. Reset clears all control state and sets the
// port mask to all ones; the stores hold no defined value until written.
module radio_timing_sequencer_core
  import rts_pkg::*;
#(
  parameter int unsigned PROGRAM_WORDS          = 64,
  parameter int unsigned QUARTER_BITS_PER_FRAME = 5000
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rts_in_if.sink    in_i,
  rts_cfg_if.sink   cfg_i,
  rts_out_if.source out_o
);

  logic [MASK_W-1:0] mask_q;
  logic              cmd_valid;
  logic              cmd_pop;
  rts_cmd_t          cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '1;
    end else if (cfg_i.valid) begin
      mask_q <= cfg_i.owned_port_mask;
    end
  end

  rts_front #(.PROGRAM_WORDS(PROGRAM_WORDS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  rts_back #(
    .PROGRAM_WORDS          (PROGRAM_WORDS),
    .QUARTER_BITS_PER_FRAME (QUARTER_BITS_PER_FRAME)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .mask_i      (mask_q),
    .out_o       (out_o)
  );

endmodule

// ----- hdl/rts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/rts_front.sv -----
// Front end: accepts input beats, classifies them into commands and holds
// them in a two-entry queue for the back end. Uses rts_pkg and rts_in_if.
module rts_front
  import rts_pkg::*;
#(
  parameter int unsigned PROGRAM_WORDS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rts_in_if.sink   in_i,
  output logic     cmd_valid_o,
  output rts_cmd_t cmd_o,
  input  logic     cmd_pop_i
);

  rts_cmd_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  rts_cmd_t   cmd_new;

  assign in_i.ready  = (count_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    cmd_new.index = in_i.word_index;
    cmd_new.word  = in_i.word;
    cmd_new.frame = in_i.frame_number;
    case (in_i.operation)
      OP_LOAD: begin
        cmd_new.kind = (32'(in_i.word_index) < PROGRAM_WORDS) ? CMD_LOAD : CMD_NOP;
      end
      OP_START: begin
        cmd_new.kind = CMD_START;
      end
      OP_TICK: begin
        cmd_new.kind = CMD_TICK;
      end
      default: begin
        cmd_new.kind = CMD_NOP;
      end
    endcase
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ----- hdl/rts_back.sv -----
// Back end: executes queued commands, owns the staging and program stores,
// walks the program and drives the result register. Uses rts_pkg, rts_ram
// and rts_out_if.
module rts_back
  import rts_pkg::*;
#(
  parameter int unsigned PROGRAM_WORDS          = 64,
  parameter int unsigned QUARTER_BITS_PER_FRAME = 5000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  rts_cmd_t          cmd_i,
  output logic              cmd_pop_o,
  input  logic [MASK_W-1:0] mask_i,
  rts_out_if.source         out_o
);

  localparam int unsigned AW = $clog2(PROGRAM_WORDS);
  localparam int unsigned CW = $clog2(PROGRAM_WORDS + 1);
  localparam logic [CW-1:0] CURSOR_END  = CW'(PROGRAM_WORDS);
  localparam logic [CW-1:0] CURSOR_LAST = CW'(PROGRAM_WORDS - 1);
  localparam logic [AW-1:0] COPY_LAST   = AW'(PROGRAM_WORDS - 1);
  localparam logic [QB_W:0] QBPF        = (QB_W + 1)'(QUARTER_BITS_PER_FRAME);

  rts_state_e         state_q, state_d;
  logic [CW-1:0]      cursor_q, cursor_d;
  logic [QB_W-1:0]    qb_q, qb_d;
  logic [1:0]         ftw_q, ftw_d;
  logic               active_q, active_d;
  logic               prev_zero_q, prev_zero_d;
  logic [AW-1:0]      copy_cnt_q, copy_cnt_d;
  logic               copy_we_q, copy_we_d;
  logic [AW-1:0]      copy_wa_q;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [QB_W:0]      rem_q, rem_d;
  logic               pend_valid_q, pend_valid_d;
  rts_result_t        pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  rts_result_t        out_res_q, out_res_d;
  logic               out_running_q, out_running_d;
  logic               out_last_q, out_last_d;

  logic [WORD_W-1:0]  stg_rdata;
  logic [WORD_W-1:0]  prog_rdata;
  logic               stg_we;
  logic               can_push;
  logic [2:0]         insn_op;
  logic [QB_W-1:0]    insn_pay;
  logic               at_end;
  logic               w_zero;
  logic               stop_run;
  logic [QB_W:0]      wait_sum;
  logic               wait_wrap;
  logic               at_stall;
  logic               do_emit;
  rts_result_t        emit_res;

  rts_ram #(.WIDTH(WORD_W), .DEPTH(PROGRAM_WORDS)) u_staging (
    .clk_i   (clk_i),
    .we_i    (stg_we),
    .waddr_i (cmd_i.index[AW-1:0]),
    .wdata_i (cmd_i.word),
    .raddr_i (copy_cnt_q),
    .rdata_o (stg_rdata)
  );

  rts_ram #(.WIDTH(WORD_W), .DEPTH(PROGRAM_WORDS)) u_program (
    .clk_i   (clk_i),
    .we_i    (copy_we_q),
    .waddr_i (copy_wa_q),
    .wdata_i (stg_rdata),
    .raddr_i (cursor_d[AW-1:0]),
    .rdata_o (prog_rdata)
  );

  assign can_push  = !out_valid_q || out_o.ready;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign stg_we    = cmd_pop_o && (cmd_i.kind == CMD_LOAD);

  assign insn_op   = prog_rdata[15:13];
  assign insn_pay  = prog_rdata[12:0];
  assign at_end    = (cursor_q == CURSOR_END);
  assign w_zero    = (prog_rdata == '0);
  assign stop_run  = at_end || (w_zero && (prev_zero_q ||
                     (cursor_q != '0 && cursor_q == CURSOR_LAST)));
  assign wait_sum  = {1'b0, qb_q} + {1'b0, insn_pay};
  assign wait_wrap = (wait_sum >= QBPF);
  assign at_stall  = !(insn_pay > qb_q);

  always_comb begin
    emit_res   = '0;
    do_emit    = 1'b0;
    case (insn_op)
      INSN_SYNCHRO: begin
        do_emit            = 1'b1;
        emit_res.kind      = KIND_SYNCHRO;
        emit_res.reg_value = insn_pay;
      end
      INSN_OFFSET: begin
        do_emit            = 1'b1;
        emit_res.kind      = KIND_OFFSET;
        emit_res.reg_value = insn_pay;
      end
      INSN_MOVE: begin
        do_emit             = mask_i[prog_rdata[4:0]];
        emit_res.kind       = KIND_MOVE;
        emit_res.move_addr  = prog_rdata[4:0];
        emit_res.move_data  = prog_rdata[12:5];
        emit_res.move_frame = frame_q;
      end
      default: begin
        do_emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_START: state_d = ST_COPY;
            CMD_TICK:  state_d = (active_q && ftw_q == 2'd1) ? ST_RUN : ST_DONE;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_COPY: begin
        if (copy_cnt_q == COPY_LAST) begin
          state_d = ST_COPY_TAIL;
        end
      end
      ST_COPY_TAIL: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (can_push) begin
          if (stop_run) begin
            state_d = ST_DONE;
          end else if (!w_zero && insn_op == INSN_AT && at_stall) begin
            state_d = ST_DONE;
          end else if (!w_zero && insn_op == INSN_WAIT && wait_wrap) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (rem_q < QBPF) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_push) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cursor_d      = cursor_q;
    qb_d          = qb_q;
    ftw_d         = ftw_q;
    active_d      = active_q;
    prev_zero_d   = prev_zero_q;
    copy_cnt_d    = copy_cnt_q;
    copy_we_d     = (state_q == ST_COPY);
    frame_d       = frame_q;
    rem_d         = rem_q;
    pend_valid_d  = pend_valid_q;
    pend_d        = pend_q;
    out_valid_d   = out_o.ready ? 1'b0 : out_valid_q;
    out_res_d     = out_res_q;
    out_running_d = out_running_q;
    out_last_d    = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_START: begin
              cursor_d    = '0;
              qb_d        = '0;
              ftw_d       = 2'd0;
              active_d    = 1'b1;
              prev_zero_d = 1'b0;
              copy_cnt_d  = '0;
              frame_d     = cmd_i.frame;
            end
            CMD_TICK: begin
              frame_d = cmd_i.frame;
              if (active_q && ftw_q != 2'd0) begin
                ftw_d = ftw_q - 2'd1;
              end
            end
            default: begin
              frame_d = frame_q;
            end
          endcase
        end
      end
      ST_COPY: begin
        copy_cnt_d = copy_cnt_q + AW'(1);
      end
      ST_RUN: begin
        if (can_push) begin
          if (stop_run) begin
            active_d = 1'b0;
          end else if (w_zero) begin
            cursor_d    = cursor_q + CW'(1);
            prev_zero_d = (cursor_q != '0);
          end else begin
            cursor_d    = cursor_q + CW'(1);
            prev_zero_d = 1'b0;
            case (insn_op)
              INSN_AT: begin
                qb_d = insn_pay;
                if (at_stall) begin
                  ftw_d = 2'd1;
                end
              end
              INSN_WAIT: begin
                if (wait_wrap) begin
                  rem_d = wait_sum;
                  ftw_d = 2'd0;
                end else begin
                  qb_d = wait_sum[QB_W-1:0];
                end
              end
              default: begin
                if (do_emit) begin
                  if (pend_valid_q) begin
                    out_valid_d   = 1'b1;
                    out_res_d     = pend_q;
                    out_running_d = 1'b1;
                    out_last_d    = 1'b0;
                  end
                  pend_valid_d = 1'b1;
                  pend_d       = emit_res;
                end
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        if (rem_q >= QBPF) begin
          rem_d = rem_q - QBPF;
          ftw_d = (ftw_q == 2'd3) ? 2'd3 : ftw_q + 2'd1;
        end else begin
          qb_d = rem_q[QB_W-1:0];
        end
      end
      ST_DONE: begin
        if (can_push) begin
          out_valid_d   = 1'b1;
          out_res_d     = pend_valid_q ? pend_q : '0;
          out_running_d = active_q;
          out_last_d    = 1'b1;
          pend_valid_d  = 1'b0;
        end
      end
      default: begin
        copy_we_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cursor_q     <= '0;
      qb_q         <= '0;
      ftw_q        <= 2'd0;
      active_q     <= 1'b0;
      prev_zero_q  <= 1'b0;
      copy_cnt_q   <= '0;
      copy_we_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cursor_q     <= cursor_d;
      qb_q         <= qb_d;
      ftw_q        <= ftw_d;
      active_q     <= active_d;
      prev_zero_q  <= prev_zero_d;
      copy_cnt_q   <= copy_cnt_d;
      copy_we_q    <= copy_we_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    copy_wa_q     <= copy_cnt_q;
    frame_q       <= frame_d;
    rem_q         <= rem_d;
    pend_q        <= pend_d;
    out_res_q     <= out_res_d;
    out_running_q <= out_running_d;
    out_last_q    <= out_last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_res_q.kind;
  assign out_o.reg_value  = out_res_q.reg_value;
  assign out_o.move_addr  = out_res_q.move_addr;
  assign out_o.move_data  = out_res_q.move_data;
  assign out_o.move_frame = out_res_q.move_frame;
  assign out_o.running    = out_running_q;
  assign out_o.last       = out_last_q;

endmodule

// ----- verif/tb_radio_timing_sequencer_core.sv -----
// Self-checking testbench for radio_timing_sequencer_core: predicts every result beat of each
// accepted item and checks them in order. Depends on rts_pkg and the channel interfaces.
module tb_radio_timing_sequencer_core;
  import rts_pkg::*;

  localparam int unsigned PROGRAM_WORDS  = 64;
  localparam int unsigned FRAME_QBITS    = 5000;
  localparam int unsigned FRAME_MAX      = 2715647;
  localparam int          RANDOM_ITEMS   = 110;
  localparam int          LONG_HOLD      = 300;
  localparam int          SETTLE_CYCLES  = 20;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam logic [1:0]  OP_IGNORED     = 2'd3;

  typedef struct packed {
    rts_kind_e          kind;
    logic [QB_W-1:0]    reg_value;
    logic [4:0]         move_addr;
    logic [7:0]         move_data;
    logic [FRAME_W-1:0] move_frame;
    logic               running;
    logic               last;
  } timing_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rts_in_if  in_ch();
  rts_out_if out_ch();
  rts_cfg_if cfg_ch();

  radio_timing_sequencer_core #(
    .PROGRAM_WORDS(PROGRAM_WORDS),
    .QUARTER_BITS_PER_FRAME(FRAME_QBITS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_ch),
    .cfg_i(cfg_ch),
    .out_o(out_ch)
  );

  always #4 clk_i = ~clk_i;

  logic [WORD_W-1:0] staged_words [PROGRAM_WORDS];
  logic [WORD_W-1:0] program_image [PROGRAM_WORDS];
  int unsigned       cursor = 0;
  logic [QB_W-1:0]   qbit_pos = '0;
  logic [1:0]        frames_left = '0;
  logic              seq_active = 1'b0;
  logic [31:0]       port_mask = '1;

  timing_event_t step_events[$];
  timing_event_t due_events[$];

  int  errors = 0;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  int  recv_hold = 0;
  bit  send_pacing = 1'b1;
  bit  recv_pacing = 1'b1;

  function automatic logic [21:0] rand_frame();
    return 22'($urandom_range(0, FRAME_MAX));
  endfunction

  function automatic logic [15:0] insn(input logic [2:0] opc, input logic [12:0] pay);
    return {opc, pay};
  endfunction

  function automatic logic [15:0] move_insn(input logic [4:0] addr, input logic [7:0] data);
    return {INSN_MOVE, data, addr};
  endfunction

  function automatic logic [15:0] random_insn();
    case ($urandom_range(0, 9))
      0, 1: return insn(INSN_SYNCHRO, 13'($urandom));
      2: return insn(INSN_OFFSET, 13'($urandom));
      3, 4: return move_insn(5'($urandom), 8'($urandom));
      5, 6: return insn(INSN_AT, 13'($urandom));
      7: begin
        if ($urandom_range(0, 3) == 0) return insn(INSN_WAIT, 13'($urandom));
        return insn(INSN_WAIT, 13'($urandom_range(0, 1500)));
      end
      8: return 16'($urandom);
      default: return 16'h0000;
    endcase
  endfunction

  task automatic add_event(input rts_kind_e kind, input logic [12:0] value,
                           input logic [4:0] addr, input logic [7:0] data,
                           input logic [21:0] frame);
    timing_event_t ev;
    ev.kind       = kind;
    ev.reg_value  = value;
    ev.move_addr  = addr;
    ev.move_data  = data;
    ev.move_frame = frame;
    ev.running    = 1'b1;
    ev.last       = 1'b0;
    step_events.push_back(ev);
  endtask

  task automatic walk_program(input logic [21:0] frame);
    logic [15:0] w;
    logic [2:0]  opc;
    logic [12:0] pay;
    int unsigned sum;
    int unsigned nf;
    while (seq_active && cursor < PROGRAM_WORDS) begin
      w = program_image[cursor];
      if (w == 16'h0000) begin
        if (cursor > 0 && (cursor + 1 >= PROGRAM_WORDS || program_image[cursor + 1] == 16'h0000))
        begin
          seq_active = 1'b0;
          return;
        end
        cursor++;
        continue;
      end
      opc = w[15:13];
      pay = w[12:0];
      cursor++;
      case (opc)
        INSN_AT: begin
          if (pay <= qbit_pos) begin
            qbit_pos = pay;
            frames_left = 2'd1;
            return;
          end
          qbit_pos = pay;
        end
        INSN_WAIT: begin
          sum = qbit_pos + pay;
          if (sum >= FRAME_QBITS) begin
            nf = sum / FRAME_QBITS;
            frames_left = (nf > 3) ? 2'd3 : 2'(nf);
            qbit_pos = 13'(sum % FRAME_QBITS);
            return;
          end
          qbit_pos = 13'(sum);
        end
        INSN_SYNCHRO: add_event(KIND_SYNCHRO, pay, 5'd0, 8'd0, 22'd0);
        INSN_OFFSET: add_event(KIND_OFFSET, pay, 5'd0, 8'd0, 22'd0);
        INSN_MOVE: begin
          if (port_mask[w[4:0]]) add_event(KIND_MOVE, 13'd0, w[4:0], w[12:5], frame);
        end
        default: ;
      endcase
    end
    seq_active = 1'b0;
  endtask

  task automatic advance_sequencer(input logic [1:0] op, input logic [5:0] idx,
                                   input logic [15:0] word, input logic [21:0] frame);
    timing_event_t status;
    int n;
    step_events = {};
    case (op)
      OP_LOAD: staged_words[idx] = word;
      OP_START: begin
        program_image = staged_words;
        cursor = 0;
        qbit_pos = '0;
        frames_left = '0;
        seq_active = 1'b1;
        walk_program(frame);
      end
      OP_TICK: begin
        if (seq_active && frames_left != 2'd0) begin
          frames_left = frames_left - 2'd1;
          if (frames_left == 2'd0) walk_program(frame);
        end
      end
      default: ;
    endcase
    if (step_events.size() == 0) begin
      status = '0;
      status.kind = KIND_STATUS;
      step_events.push_back(status);
    end
    n = step_events.size() - 1;
    step_events[n].running = seq_active;
    step_events[n].last = 1'b1;
    foreach (step_events[i]) due_events.push_back(step_events[i]);
  endtask

  task automatic send_cmd(input logic [1:0] op, input logic [5:0] idx, input logic [15:0] word,
                          input logic [21:0] frame);
    int gap;
    gap = send_pacing ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.word_index   <= idx;
    in_ch.word         <= word;
    in_ch.frame_number <= frame;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    advance_sequencer(op, idx, word, frame);
    items_sent++;
  endtask

  task automatic load_word(input logic [5:0] idx, input logic [15:0] w);
    send_cmd(OP_LOAD, idx, w, rand_frame());
  endtask

  task automatic start_run();
    send_cmd(OP_START, 6'($urandom), 16'($urandom), rand_frame());
  endtask

  task automatic tick_until_idle();
    while (seq_active) begin
      if ($urandom_range(0, 5) == 0) load_word(6'($urandom), 16'($urandom));
      send_cmd(OP_TICK, 6'($urandom), 16'($urandom), rand_frame());
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_port_mask(input logic [31:0] mask);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.owned_port_mask <= mask;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    port_mask = mask;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  task automatic check_event();
    timing_event_t want;
    if (due_events.size() == 0) begin
      $display("%0t: unexpected result beat, expected none, actual kind %0d", $time,
               out_ch.kind);
      errors++;
    end else begin
      want = due_events.pop_front();
      compare_field("kind", want.kind, out_ch.kind);
      compare_field("reg_value", want.reg_value, out_ch.reg_value);
      compare_field("move_addr", want.move_addr, out_ch.move_addr);
      compare_field("move_data", want.move_data, out_ch.move_data);
      compare_field("move_frame", want.move_frame, out_ch.move_frame);
      compare_field("running", want.running, out_ch.running);
      compare_field("last", want.last, out_ch.last);
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = recv_pacing ? $urandom_range(0, 3) : 0;
      if (recv_hold > 0) begin
        stall = recv_hold;
        recv_hold = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      check_event();
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Every staging entry is written here before any start, so no start ever copies an
  // undefined word.
  task automatic test_full_store();
    logic [15:0] w;
    for (int i = 0; i < PROGRAM_WORDS; i++) begin
      case (i % 3)
        0: w = insn(INSN_SYNCHRO, 13'($urandom));
        1: w = insn(INSN_OFFSET, 13'($urandom));
        default: w = move_insn(5'($urandom), 8'($urandom));
      endcase
      load_word(6'(i), w);
    end
    start_run();
    load_word(6'd63, 16'h0000);
    start_run();
    load_word(6'd0, 16'h0000);
    start_run();
  endtask

  task automatic test_instruction_set();
    load_word(6'd0, 16'h0000);
    load_word(6'd1, insn(INSN_SYNCHRO, 13'h1FFF));
    load_word(6'd2, insn(INSN_OFFSET, 13'h0000));
    load_word(6'd3, move_insn(5'h1F, 8'hFF));
    load_word(6'd4, move_insn(5'h00, 8'h00));
    load_word(6'd5, 16'h0000);
    load_word(6'd6, 16'h1FFF);
    load_word(6'd7, 16'hC123);
    load_word(6'd8, 16'hFFFF);
    load_word(6'd9, insn(INSN_OFFSET, 13'h0AAA));
    load_word(6'd10, 16'h0000);
    load_word(6'd11, 16'h0000);
    send_cmd(OP_START, 6'h3F, 16'hFFFF, 22'(FRAME_MAX));
    send_cmd(OP_IGNORED, 6'h2A, 16'h5555, rand_frame());
    send_cmd(OP_TICK, 6'h15, 16'hAAAA, rand_frame());
  endtask

  task automatic test_frame_timing();
    load_word(6'd0, insn(INSN_AT, 13'd100));
    load_word(6'd1, insn(INSN_SYNCHRO, 13'd1));
    load_word(6'd2, insn(INSN_AT, 13'd100));
    load_word(6'd3, insn(INSN_SYNCHRO, 13'd2));
    load_word(6'd4, insn(INSN_WAIT, 13'd4900));
    load_word(6'd5, insn(INSN_SYNCHRO, 13'd3));
    load_word(6'd6, insn(INSN_AT, 13'd8191));
    load_word(6'd7, insn(INSN_WAIT, 13'd8191));
    load_word(6'd8, move_insn(5'd5, 8'hA5));
    load_word(6'd9, insn(INSN_AT, 13'd0));
    load_word(6'd10, 16'h0000);
    load_word(6'd11, 16'h0000);
    start_run();
    send_cmd(OP_TICK, 6'd0, 16'h0000, 22'd0);
    load_word(6'd40, random_insn());
    tick_until_idle();
    send_cmd(OP_TICK, 6'($urandom), 16'($urandom), rand_frame());
  endtask

  task automatic test_port_mask();
    logic [31:0] masks [5];
    masks = '{32'h0000_0000, 32'h8000_0001, 32'h7FFF_FFFE, 32'($urandom), 32'hFFFF_FFFF};
    load_word(6'd0, move_insn(5'd0, 8'h5A));
    load_word(6'd1, move_insn(5'd31, 8'hC3));
    load_word(6'd2, move_insn(5'($urandom), 8'($urandom)));
    load_word(6'd3, 16'h0000);
    load_word(6'd4, 16'h0000);
    foreach (masks[i]) begin
      drain_results();
      write_port_mask(masks[i]);
      start_run();
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    drain_results();
    recv_hold = LONG_HOLD;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 5; i++) load_word(6'(i), random_insn());
      load_word(6'd5, 16'h0000);
      load_word(6'd6, 16'h0000);
      start_run();
      tick_until_idle();
    end
    drain_results();
  endtask

  task automatic test_random_programs();
    int first_item;
    int len;
    int programs;
    logic [31:0] mask;
    first_item = items_sent;
    programs = 0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      send_pacing = $urandom_range(0, 3) != 0;
      recv_pacing = $urandom_range(0, 3) != 0;
      if (programs % 6 == 5) begin
        drain_results();
        case ($urandom_range(0, 3))
          0: mask = '0;
          1: mask = '1;
          default: mask = $urandom;
        endcase
        write_port_mask(mask);
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          send_cmd(2'($urandom_range(0, 3)), 6'($urandom), 16'($urandom), rand_frame());
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) load_word(6'(i), random_insn());
        if ($urandom_range(0, 4) != 0) begin
          load_word(6'(len), 16'h0000);
          load_word(6'(len + 1), 16'h0000);
        end
        start_run();
      end
      tick_until_idle();
      programs++;
    end
    drain_results();
  endtask

  initial begin
    in_ch.valid            <= 1'b0;
    in_ch.operation        <= OP_LOAD;
    in_ch.word_index       <= '0;
    in_ch.word             <= '0;
    in_ch.frame_number     <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.owned_port_mask <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_store();
    test_instruction_set();
    test_frame_timing();
    test_port_mask();
    test_backpressure();
    test_random_programs();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
